>>> hdl/adc_pkg.sv
// Shared constants and types for the ant direction chooser.
package adc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int PHER_BITS_DEF  = 16;

  localparam int FRAC_BITS  = 16;
  localparam int FRAC_ONE   = 1 << FRAC_BITS;
  // Quotient of a^2 * 2^32 / S lies in 0..2^32.
  localparam int QUOT_W     = 2 * FRAC_BITS + 1;
  // Axis ratio in Q1.16, 0..65536.
  localparam int RATIO_W    = FRAC_BITS + 1;
  // Heading term in Q2.16, 0..131072.
  localparam int HEAD_W     = FRAC_BITS + 2;
  localparam int DRAW_W     = 10;
  localparam int DRAW_SCALE = 1000;
  localparam int NUM_DIRS   = 4;
  localparam int DIR_W      = 2;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

endpackage

>>> hdl/adc_in_if.sv
// Input channel: agent position, target, neighbour pheromone and random draw.
interface adc_in_if #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEF,
  parameter int PHER_BITS  = adc_pkg::PHER_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         cur_x;
  logic [COORD_BITS-1:0]         cur_y;
  logic [COORD_BITS-1:0]         target_x;
  logic [COORD_BITS-1:0]         target_y;
  logic [PHER_BITS-1:0]          pher_up;
  logic [PHER_BITS-1:0]          pher_left;
  logic [PHER_BITS-1:0]          pher_right;
  logic [PHER_BITS-1:0]          pher_down;
  logic [adc_pkg::DRAW_W-1:0]    random_draw;

  modport source (
    output valid, cur_x, cur_y, target_x, target_y,
           pher_up, pher_left, pher_right, pher_down, random_draw,
    input  ready
  );
  modport sink (
    input  valid, cur_x, cur_y, target_x, target_y,
           pher_up, pher_left, pher_right, pher_down, random_draw,
    output ready
  );
endinterface

>>> hdl/adc_out_if.sv
// Result channel: chosen move and at-target flag.
interface adc_out_if;
  logic                       valid;
  logic                       ready;
  logic [adc_pkg::DIR_W-1:0]  direction;
  logic                       at_target;

  modport source (output valid, direction, at_target, input ready);
  modport sink   (input valid, direction, at_target, output ready);
endinterface

>>> hdl/adc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
module adc_div_pipe #(
  parameter int DEN_W  = 21,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1,
  localparam int Q_W   = adc_pkg::QUOT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [LANES-1:0][DEN_W-1:0]     in_num,
  input  logic [DEN_W-1:0]                in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_vld,
  output logic [LANES-1:0][Q_W-1:0]       out_quot,
  output logic [SIDE_W-1:0]               out_side
);

  logic                        vld_r  [Q_W];
  logic [DEN_W-1:0]            den_r  [Q_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quot_r [Q_W];
  logic [SIDE_W-1:0]           side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    logic                        vld_i;
    logic [DEN_W-1:0]            den_i;
    logic [LANES-1:0][DEN_W-1:0] rem_i;
    logic [LANES-1:0][Q_W-1:0]   quot_i;
    logic [SIDE_W-1:0]           side_i;
    logic [LANES-1:0][DEN_W-1:0] rem_nxt;
    logic [LANES-1:0][Q_W-1:0]   quot_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign den_i  = in_den;
      assign rem_i  = in_num;
      assign quot_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign den_i  = den_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign quot_i = quot_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      logic [DEN_W:0] part;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        // The first step compares the numerator itself; later ones double the remainder.
        part = (k == 0) ? {1'b0, rem_i[l]} : {rem_i[l], 1'b0};
        ge   = (part >= {1'b0, den_i});
        rem_nxt[l]  = ge ? DEN_W'(part - {1'b0, den_i}) : part[DEN_W-1:0];
        quot_nxt[l] = {quot_i[l][Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_i;
        rem_r[k]  <= rem_nxt;
        quot_r[k] <= quot_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_quot = quot_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

>>> hdl/adc_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, several lanes in step.
module adc_sqrt_pipe #(
  parameter int IN_W   = 34,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1,
  localparam int RT_W  = (IN_W + 1) / 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [LANES-1:0][IN_W-1:0]    in_val,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [LANES-1:0][RT_W-1:0]    out_root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int V_W   = 2 * RT_W;
  localparam int REM_W = RT_W + 2;

  logic                        vld_r  [RT_W];
  logic [LANES-1:0][V_W-1:0]   val_r  [RT_W];
  logic [LANES-1:0][REM_W-1:0] rem_r  [RT_W];
  logic [LANES-1:0][RT_W-1:0]  root_r [RT_W];
  logic [SIDE_W-1:0]           side_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stg
    logic                        vld_i;
    logic [LANES-1:0][V_W-1:0]   val_i;
    logic [LANES-1:0][REM_W-1:0] rem_i;
    logic [LANES-1:0][RT_W-1:0]  root_i;
    logic [SIDE_W-1:0]           side_i;
    logic [LANES-1:0][REM_W-1:0] rem_nxt;
    logic [LANES-1:0][RT_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          val_i[l] = V_W'(in_val[l]);
        end
      end
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign val_i  = val_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        // Bring down the next two bits and try the odd step 4*root + 1.
        rem_sh = {rem_i[l], val_i[l][V_W-1-2*k -: 2]};
        trial  = {(REM_W-RT_W)'(0), root_i[l], 2'b01};
        if (rem_sh >= trial) begin
          rem_nxt[l]  = REM_W'(rem_sh - trial);
          root_nxt[l] = {root_i[l][RT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = rem_sh[REM_W-1:0];
          root_nxt[l] = {root_i[l][RT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= val_i;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_side = side_r[RT_W-1];

endmodule

>>> hdl/ant_direction_chooser.sv
// Ant direction chooser: weighted random pick of one of four grid moves.
// Takes one word per clock while the output is not held and returns one
// result word per input word, in order. The registered steps, in order, are
// a distance stage, 33 stages of the restoring divider that forms the axis
// ratios, 17 stages of the ratio square root, the heading-by-pheromone
// multiply, the weight square root, the prefix sum and the draw compare that
// loads the output register. Whole pipeline holds while a result waits at
// the output and the sink is not ready.
module ant_direction_chooser #(
  parameter int COORD_BITS = adc_pkg::COORD_BITS_DEF,
  parameter int PHER_BITS  = adc_pkg::PHER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  adc_in_if.sink         in_ch,
  adc_out_if.source      out_ch
);

  localparam int CB      = COORD_BITS;
  localparam int PB      = PHER_BITS;
  localparam int ND      = adc_pkg::NUM_DIRS;
  localparam int DW      = adc_pkg::DRAW_W;
  localparam int SQ_W    = 2 * CB;
  localparam int S_W     = 2 * CB + 1;
  localparam int HW      = adc_pkg::HEAD_W;
  localparam int RW      = adc_pkg::RATIO_W;
  localparam int PROD_W  = HW + PB;
  localparam int WT_W    = (PROD_W + 1) / 2;
  localparam int CUM_W   = WT_W + 2;
  localparam int CMP_W   = DW + CUM_W;
  // Sideband through the divider and ratio root: away flags, at-target, draw, pheromones.
  localparam int SIDE1_W = ND + 1 + DW + ND * PB;
  localparam int SIDE2_W = 1 + DW;
  // Lanes whose own axis is the column: left and right.
  localparam logic [ND-1:0] OWN_X = 4'b0110;

  logic en;
  logic out_vld_r;

  // Advance everything unless the output word is held.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Distance stage.
  logic [CB-1:0]          dx, dy;
  logic [ND-1:0]          away;
  logic                   sa_vld_r;
  logic [SQ_W-1:0]        sa_dx2_r, sa_dy2_r;
  logic [S_W-1:0]         sa_s_r;
  logic [ND-1:0]          sa_away_r;
  logic [DW-1:0]          sa_draw_r;
  logic [ND-1:0][PB-1:0]  sa_pher_r;

  always_comb begin
    dx = (in_ch.cur_x >= in_ch.target_x) ? in_ch.cur_x - in_ch.target_x
                                         : in_ch.target_x - in_ch.cur_x;
    dy = (in_ch.cur_y >= in_ch.target_y) ? in_ch.cur_y - in_ch.target_y
                                         : in_ch.target_y - in_ch.cur_y;
    away[0] = in_ch.cur_y < in_ch.target_y;
    away[1] = in_ch.cur_x < in_ch.target_x;
    away[2] = in_ch.cur_x > in_ch.target_x;
    away[3] = in_ch.cur_y > in_ch.target_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (en) begin
      sa_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dx2_r     <= SQ_W'(dx) * SQ_W'(dx);
      sa_dy2_r     <= SQ_W'(dy) * SQ_W'(dy);
      sa_s_r       <= S_W'(SQ_W'(dx) * SQ_W'(dx)) + S_W'(SQ_W'(dy) * SQ_W'(dy));
      sa_away_r    <= away;
      sa_draw_r    <= in_ch.random_draw;
      sa_pher_r[0] <= in_ch.pher_up;
      sa_pher_r[1] <= in_ch.pher_left;
      sa_pher_r[2] <= in_ch.pher_right;
      sa_pher_r[3] <= in_ch.pher_down;
    end
  end

  // Ratio squares: a^2 * 2^32 / S, lane 0 column, lane 1 row.
  logic [1:0][S_W-1:0]                div_num;
  logic                               div_vld;
  logic [1:0][adc_pkg::QUOT_W-1:0]    div_quot;
  logic [SIDE1_W-1:0]                 div_side;

  assign div_num[0] = S_W'(sa_dx2_r);
  assign div_num[1] = S_W'(sa_dy2_r);

  adc_div_pipe #(
    .DEN_W  (S_W),
    .LANES  (2),
    .SIDE_W (SIDE1_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sa_vld_r),
    .in_num   (div_num),
    .in_den   (sa_s_r),
    .in_side  ({sa_away_r, (sa_s_r == '0), sa_draw_r, sa_pher_r}),
    .out_vld  (div_vld),
    .out_quot (div_quot),
    .out_side (div_side)
  );

  logic                  rt_vld;
  logic [1:0][RW-1:0]    rt_ratio;
  logic [SIDE1_W-1:0]    rt_side;

  adc_sqrt_pipe #(
    .IN_W   (adc_pkg::QUOT_W),
    .LANES  (2),
    .SIDE_W (SIDE1_W)
  ) u_ratio_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld),
    .in_val   (div_quot),
    .in_side  (div_side),
    .out_vld  (rt_vld),
    .out_root (rt_ratio),
    .out_side (rt_side)
  );

  // Heading term times pheromone.
  logic [ND-1:0]          rt_away;
  logic                   rt_at;
  logic [DW-1:0]          rt_draw;
  logic [ND-1:0][PB-1:0]  rt_pher;
  logic [ND-1:0][HW-1:0]  head;
  logic                   sh_vld_r;
  logic [ND-1:0][PROD_W-1:0] sh_prod_r;
  logic [SIDE2_W-1:0]     sh_side_r;

  assign rt_pher = rt_side[ND*PB-1:0];
  assign rt_draw = rt_side[ND*PB +: DW];
  assign rt_at   = rt_side[ND*PB + DW];
  assign rt_away = rt_side[ND*PB + DW + 1 +: ND];

  always_comb begin
    logic [RW-1:0] r_own, r_other;
    for (int i = 0; i < ND; i++) begin
      r_own   = OWN_X[i] ? rt_ratio[0] : rt_ratio[1];
      r_other = OWN_X[i] ? rt_ratio[1] : rt_ratio[0];
      head[i] = rt_away[i] ? HW'(r_other) : HW'(adc_pkg::FRAC_ONE) + HW'(r_own);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_vld_r <= 1'b0;
    end else if (en) begin
      sh_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ND; i++) begin
        sh_prod_r[i] <= PROD_W'(head[i]) * PROD_W'(rt_pher[i]);
      end
      sh_side_r <= {rt_at, rt_draw};
    end
  end

  logic                      wt_vld;
  logic [ND-1:0][WT_W-1:0]   wt;
  logic [SIDE2_W-1:0]        wt_side;

  adc_sqrt_pipe #(
    .IN_W   (PROD_W),
    .LANES  (ND),
    .SIDE_W (SIDE2_W)
  ) u_weight_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sh_vld_r),
    .in_val   (sh_prod_r),
    .in_side  (sh_side_r),
    .out_vld  (wt_vld),
    .out_root (wt),
    .out_side (wt_side)
  );

  // Prefix sums of the weights; the last is the total.
  logic                      sc_vld_r;
  logic [ND-1:0][CUM_W-1:0]  sc_cum_r;
  logic [SIDE2_W-1:0]        sc_side_r;
  logic [ND-1:0][CUM_W-1:0]  cum;

  always_comb begin
    cum[0] = CUM_W'(wt[0]);
    for (int i = 1; i < ND; i++) begin
      cum[i] = cum[i-1] + CUM_W'(wt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (en) begin
      sc_vld_r <= wt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_cum_r  <= cum;
      sc_side_r <= wt_side;
    end
  end

  // Compare draw * total against 1000 * prefix; the first lane that wins takes it; at target, up.
  logic [DW-1:0]       sc_draw;
  logic                sc_at;
  logic [CMP_W-1:0]    lhs;
  adc_pkg::dir_t       dir_nxt;
  logic                found;
  adc_pkg::dir_t       out_dir_r;
  logic                out_at_r;

  assign sc_draw = sc_side_r[DW-1:0];
  assign sc_at   = sc_side_r[DW];
  assign lhs     = CMP_W'(sc_draw) * CMP_W'(sc_cum_r[ND-1]);

  always_comb begin
    found   = 1'b0;
    dir_nxt = (sc_draw >= DW'(adc_pkg::DRAW_SCALE)) ? adc_pkg::DIR_LEFT
                                                    : adc_pkg::DIR_UP;
    for (int i = 0; i < ND; i++) begin
      if (!found && (lhs < CMP_W'(adc_pkg::DRAW_SCALE) * CMP_W'(sc_cum_r[i]))) begin
        found   = 1'b1;
        dir_nxt = adc_pkg::dir_t'(adc_pkg::DIR_W'(i));
      end
    end
    if (sc_at) begin
      dir_nxt = adc_pkg::DIR_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dir_r <= dir_nxt;
      out_at_r  <= sc_at;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.at_target = out_at_r;

endmodule
